// ===== hw/rtl/vmf_pkg.sv =====
// ----------------------------------------------------------------------------
// vmf_pkg : shared types and constants of the 3x3x3 volume median filter
// Request codes, transfer payload structs and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package vmf_pkg;

  // Field widths of the transfer payloads
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned INDEX_W  = 12;
  localparam int unsigned CFG_W    = 5;

  // Side of the cube after reset
  localparam int unsigned SIDE_RST = 16;

  // Neighbourhood size and counter widths
  localparam int unsigned NEIGH_MAX = 27;
  localparam int unsigned NEIGH_W   = 5;
  localparam int unsigned SEL_W     = 4;

  // Request codes
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_FETCH = 1'b1;

  typedef struct packed {
    logic                       req_type;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median_value;
    logic [INDEX_W-1:0]         voxel_index;
    logic                       last_voxel;
    logic                       ready_res;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATHER,
    ST_DRAIN,
    ST_SELECT,
    ST_EMIT
  } vmf_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/volume_median_filter_3x3x3.sv =====
// ----------------------------------------------------------------------------
// volume_median_filter_3x3x3 : median of the clipped 3x3x3 neighbourhood
// Stores a cube of side S, then filters it voxel by voxel on fetch requests.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+---------------------------
//  in_     | input     | in_valid / in_ready | in_item_t  (load or fetch)
//  out_    | output    | out_valid/out_ready | out_item_t (fetch result)
//  cfg_    | input     | cfg_valid/cfg_ready | side of the cube, 5 bits
//
// A fetch of a loaded cube walks the 27 neighbour offsets through the voxel
// memory, inserts each read that lies inside the cube into a sorted register
// row, then shifts the row (n-1)/2 times to reach the middle. A fetch before
// the cube is complete skips the walk and gives a zero result with ready_res
// clear. After reset or a side write the input waits while S*S and S*S*S
// settle. A stalled result is held in the output register; loads are still
// taken while it waits.
//
`default_nettype none

module volume_median_filter_3x3x3
  import vmf_pkg::*;
#(
  parameter int unsigned MAX_SIDE    = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam int unsigned DEPTH    = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int unsigned SQ_W     = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int unsigned CRD_W    = $clog2(MAX_SIDE);
  localparam int unsigned NA_W     = CNT_W + 2;
  localparam int unsigned RST_SIDE = (SIDE_RST > MAX_SIDE) ? MAX_SIDE : SIDE_RST;
  localparam int unsigned SB       = SAMPLE_BITS;

  // Coordinate plus offset digit lands inside the cube
  function automatic logic coord_ok(input logic [CRD_W-1:0] c, input logic [1:0] d,
                                    input logic [SIDE_W-1:0] s);
    logic [SIDE_W+1:0] t;
    t = (SIDE_W+2)'(c) + (SIDE_W+2)'(d);
    return (t != '0) && (t <= (SIDE_W+2)'(s));
  endfunction

  vmf_state_t state_r, state_nxt;

  logic [SIDE_W-1:0] side_r;
  logic [SQ_W-1:0]   side_sq_r;
  logic [CNT_W-1:0]  total_r;
  logic [1:0]        settle_r;

  logic [CNT_W-1:0]  load_ptr_r;
  logic [ADDR_W-1:0] fetch_ptr_r;
  logic [CRD_W-1:0]  fx_r, fy_r, fz_r;
  logic              loaded_r;

  logic [1:0]        dx_r, dy_r, dz_r;
  logic [NEIGH_W-1:0] n_r;
  logic [SEL_W-1:0]  sel_cnt_r;
  logic              ins_valid_r;

  logic [SB-1:0]        mem [DEPTH];
  logic signed [SB-1:0] rd_data_r;
  logic signed [SB-1:0] sort_r [NEIGH_MAX];

  logic [SB-1:0]     res_med_r;
  logic [ADDR_W-1:0] res_idx_r;
  logic              res_last_r;
  logic              res_ready_r;

  logic      out_valid_r;
  out_item_t out_data_r;

  // Handshakes
  logic in_fire, cfg_fire, out_load;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign in_ready  = (state_r == ST_IDLE) && (settle_r == '0);
  assign in_fire   = in_valid && in_ready;
  assign out_load  = (state_r == ST_EMIT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Clamp the written side into 2..MAX_SIDE
  logic [SIDE_W+CFG_W-1:0] cfg_ext;
  logic [SIDE_W-1:0]       side_new;
  assign cfg_ext = {{SIDE_W{1'b0}}, cfg_data};
  always_comb begin
    priority if (cfg_ext < (SIDE_W+CFG_W)'(2)) begin
      side_new = SIDE_W'(2);
    end else if (cfg_ext > (SIDE_W+CFG_W)'(MAX_SIDE)) begin
      side_new = SIDE_W'(MAX_SIDE);
    end else begin
      side_new = cfg_ext[SIDE_W-1:0];
    end
  end

  // Neighbour address and bounds for the current offset
  logic [NA_W-1:0] nbr_addr, dy_off, dz_off;
  logic            nbr_ok, gather_end;
  always_comb begin
    unique case (dy_r)
      2'd0:    dy_off = -NA_W'(side_r);
      2'd1:    dy_off = '0;
      default: dy_off = NA_W'(side_r);
    endcase
    unique case (dz_r)
      2'd0:    dz_off = -NA_W'(side_sq_r);
      2'd1:    dz_off = '0;
      default: dz_off = NA_W'(side_sq_r);
    endcase
    nbr_addr = NA_W'(fetch_ptr_r) + NA_W'(dx_r) - NA_W'(1) + dy_off + dz_off;
    nbr_ok   = coord_ok(fx_r, dx_r, side_r) && coord_ok(fy_r, dy_r, side_r) &&
               coord_ok(fz_r, dz_r, side_r);
  end
  assign gather_end = (dx_r == 2'd2) && (dy_r == 2'd2) && (dz_r == 2'd2);

  // Sample taken over SAMPLE_BITS bits
  logic [SB+SAMPLE_W-1:0] sample_ext;
  assign sample_ext = {{SB{in_data.sample[SAMPLE_W-1]}}, in_data.sample};

  logic load_we;
  assign load_we = in_fire && (in_data.req_type == REQ_LOAD) && !loaded_r &&
                   (load_ptr_r < total_r);

  // Voxel memory: one write and one read a cycle, read data registered
  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[load_ptr_r[ADDR_W-1:0]] <= sample_ext[SB-1:0];
    end
    rd_data_r <= mem[nbr_addr[ADDR_W-1:0]];
  end

  // Insert the returned neighbour into the sorted row
  logic                 ge [NEIGH_MAX];
  logic signed [SB-1:0] ins_row [NEIGH_MAX];
  always_comb begin
    for (int i = 0; i < NEIGH_MAX; i++) begin
      ge[i] = (NEIGH_W'(i) < n_r) && (sort_r[i] <= rd_data_r);
    end
    for (int i = 0; i < NEIGH_MAX; i++) begin
      if (ge[i]) begin
        ins_row[i] = sort_r[i];
      end else if (i == 0) begin
        ins_row[i] = rd_data_r;
      end else if (ge[(i == 0) ? 0 : i-1]) begin
        ins_row[i] = rd_data_r;
      end else begin
        ins_row[i] = sort_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // Count of samples after the final insert and the shifts it needs
  logic [NEIGH_W-1:0] n_fin, n_fin_m1;
  assign n_fin    = n_r + NEIGH_W'(ins_valid_r);
  assign n_fin_m1 = n_fin - NEIGH_W'(1);

  // Middle value, mean of the two middle values floored for an even count
  logic signed [SB:0]  mid_sum;
  logic [SB-1:0]       mid_val;
  assign mid_sum = {sort_r[0][SB-1], sort_r[0]} + {sort_r[1][SB-1], sort_r[1]};
  assign mid_val = n_r[0] ? sort_r[0] : mid_sum[SB:1];

  logic select_done, last_vox;
  assign select_done = (state_r == ST_SELECT) && (sel_cnt_r == '0);
  assign last_vox    = (CNT_W'(fetch_ptr_r) == (total_r - CNT_W'(1)));

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_data.req_type == REQ_FETCH)) begin
          state_nxt = loaded_r ? ST_GATHER : ST_EMIT;
        end
      end
      ST_GATHER: begin
        if (gather_end) state_nxt = ST_DRAIN;
      end
      ST_DRAIN:  state_nxt = ST_SELECT;
      ST_SELECT: begin
        if (sel_cnt_r == '0) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Side and the products derived from it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r    <= SIDE_W'(RST_SIDE);
      side_sq_r <= SQ_W'(RST_SIDE * RST_SIDE);
      total_r   <= CNT_W'(RST_SIDE * RST_SIDE * RST_SIDE);
      settle_r  <= 2'd2;
    end else begin
      side_sq_r <= SQ_W'(side_r * side_r);
      total_r   <= CNT_W'(side_sq_r * side_r);
      if (cfg_fire) begin
        side_r   <= side_new;
        settle_r <= 2'd2;
      end else if (settle_r != '0) begin
        settle_r <= settle_r - 2'd1;
      end
    end
  end

  // Load and fetch pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_ptr_r  <= '0;
      fetch_ptr_r <= '0;
      fx_r        <= '0;
      fy_r        <= '0;
      fz_r        <= '0;
      loaded_r    <= 1'b0;
    end else if (cfg_fire) begin
      load_ptr_r  <= '0;
      fetch_ptr_r <= '0;
      fx_r        <= '0;
      fy_r        <= '0;
      fz_r        <= '0;
      loaded_r    <= 1'b0;
    end else if (load_we) begin
      load_ptr_r <= load_ptr_r + CNT_W'(1);
      if (load_ptr_r + CNT_W'(1) >= total_r) loaded_r <= 1'b1;
    end else if (select_done) begin
      if (last_vox) begin
        load_ptr_r  <= '0;
        fetch_ptr_r <= '0;
        fx_r        <= '0;
        fy_r        <= '0;
        fz_r        <= '0;
        loaded_r    <= 1'b0;
      end else begin
        fetch_ptr_r <= fetch_ptr_r + ADDR_W'(1);
        if ((SIDE_W+1)'(fx_r) == (SIDE_W+1)'(side_r) - (SIDE_W+1)'(1)) begin
          fx_r <= '0;
          if ((SIDE_W+1)'(fy_r) == (SIDE_W+1)'(side_r) - (SIDE_W+1)'(1)) begin
            fy_r <= '0;
            fz_r <= fz_r + CRD_W'(1);
          end else begin
            fy_r <= fy_r + CRD_W'(1);
          end
        end else begin
          fx_r <= fx_r + CRD_W'(1);
        end
      end
    end
  end

  // Offset walk, insert count and shift count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dx_r        <= '0;
      dy_r        <= '0;
      dz_r        <= '0;
      n_r         <= '0;
      sel_cnt_r   <= '0;
      ins_valid_r <= 1'b0;
    end else begin
      ins_valid_r <= (state_r == ST_GATHER) && nbr_ok;
      if (ins_valid_r) n_r <= n_r + NEIGH_W'(1);
      unique case (state_r)
        ST_IDLE: begin
          dx_r <= '0;
          dy_r <= '0;
          dz_r <= '0;
          n_r  <= '0;
        end
        ST_GATHER: begin
          if (dx_r == 2'd2) begin
            dx_r <= '0;
            if (dy_r == 2'd2) begin
              dy_r <= '0;
              dz_r <= dz_r + 2'd1;
            end else begin
              dy_r <= dy_r + 2'd1;
            end
          end else begin
            dx_r <= dx_r + 2'd1;
          end
        end
        ST_DRAIN:  sel_cnt_r <= n_fin_m1[SEL_W:1];
        ST_SELECT: begin
          if (sel_cnt_r != '0) sel_cnt_r <= sel_cnt_r - SEL_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Sorted row: insert while gathering, shift toward the middle when selecting
  always_ff @(posedge clk) begin
    if (ins_valid_r) begin
      for (int i = 0; i < NEIGH_MAX; i++) sort_r[i] <= ins_row[i];
    end else if ((state_r == ST_SELECT) && (sel_cnt_r != '0)) begin
      for (int i = 0; i < NEIGH_MAX - 1; i++) sort_r[i] <= sort_r[i+1];
    end
  end

  // Stage the result of a fetch
  always_ff @(posedge clk) begin
    if (in_fire && (in_data.req_type == REQ_FETCH) && !loaded_r) begin
      res_med_r   <= '0;
      res_idx_r   <= fetch_ptr_r;
      res_last_r  <= 1'b0;
      res_ready_r <= 1'b0;
    end else if (select_done) begin
      res_med_r   <= mid_val;
      res_idx_r   <= fetch_ptr_r;
      res_last_r  <= last_vox;
      res_ready_r <= 1'b1;
    end
  end

  // Output register: hold the result until its transfer
  logic [SB+SAMPLE_W-1:0]    med_ext;
  logic [ADDR_W+INDEX_W-1:0] idx_ext;
  assign med_ext = {{SAMPLE_W{1'b0}}, res_med_r};
  assign idx_ext = {{INDEX_W{1'b0}}, res_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.median_value <= med_ext[SAMPLE_W-1:0];
      out_data_r.voxel_index  <= idx_ext[INDEX_W-1:0];
      out_data_r.last_voxel   <= res_last_r;
      out_data_r.ready_res    <= res_ready_r;
    end
  end

  // Checks on the sequencer and pointers
  a_gather_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GATHER) |-> loaded_r)
    else $error("neighbour walk started on an incomplete cube");

  a_count_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SELECT) |-> (n_r == NEIGH_W'(8) || n_r == NEIGH_W'(12) ||
                                n_r == NEIGH_W'(18) || n_r == NEIGH_W'(27)))
    else $error("neighbour count is not a corner, edge, face or interior count");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (settle_r == '0) |-> (load_ptr_r <= total_r))
    else $error("load pointer passed the cube size");

  a_last_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last_voxel) |-> out_data_r.ready_res)
    else $error("final voxel flagged on a result from an incomplete cube");

endmodule

`default_nettype wire
